// ===== rtl/vdp_pkg.sv =====
// ----------------------------------------------------------------------------
// vdp_pkg
// Shared types, port codes and helpers for the VGA DAC palette port block.
// ----------------------------------------------------------------------------
package vdp_pkg;

   localparam int PALETTE_ENTRIES_DEF = 256;

   localparam int INDEX_W = 8;
   localparam int ENTRY_W = 18;
   localparam int COMP_W  = 6;

   localparam logic [15:0] PORT_DAC_READ_INDEX  = 16'h03C7;
   localparam logic [15:0] PORT_DAC_WRITE_INDEX = 16'h03C8;
   localparam logic [15:0] PORT_DAC_DATA        = 16'h03C9;
   localparam logic [15:0] PORT_INPUT_STATUS    = 16'h03DA;

   localparam logic [COMP_W-1:0] RETRACE_STATUS = 6'd8;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [1:0] MODE_NONE    = 2'd0;
   localparam logic [1:0] MODE_PALETTE = 2'd1;

   localparam logic [1:0] CSR_VIDEO_MODE = 2'd0;
   localparam logic [1:0] CSR_COLOR_BITS = 2'd1;

   localparam logic [1:0] STEP_RED   = 2'd0;
   localparam logic [1:0] STEP_GREEN = 2'd1;
   localparam logic [1:0] STEP_BLUE  = 2'd2;

   typedef struct packed {
      logic               rd_en;
      logic [INDEX_W-1:0] rd_addr;
      logic               wr_en;
      logic [INDEX_W-1:0] wr_addr;
      logic [ENTRY_W-1:0] wr_data;
   } mem_req_type;

   // index mask from the colour-count exponent, saturating at 8 bits
   function automatic logic [INDEX_W-1:0] index_mask(input logic [3:0] bits);
      logic [3:0] sat;
      logic [8:0] full;
      sat  = (bits > 4'd8) ? 4'd8 : bits;
      full = (9'd1 << sat) - 9'd1;
      return full[INDEX_W-1:0];
   endfunction

   // bit offset of the component selected by the step
   function automatic logic [4:0] comp_shift(input logic [1:0] step);
      logic [4:0] sh;
      case (step)
         STEP_GREEN: sh = 5'd6;
         STEP_BLUE:  sh = 5'd12;
         default:    sh = 5'd0;
      endcase
      return sh;
   endfunction

endpackage

// ===== rtl/vga_dac_palette_port_top.sv =====
// ----------------------------------------------------------------------------
// vga_dac_palette_port_top
// VGA DAC palette port: decodes port reads and writes, builds colours one
// component at a time and keeps them in a palette memory.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_cmd, req_port, req_write_data
//   rsp_     out        rsp_valid/rsp_stall  rsp_read_data, rsp_status
//   csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// For each access, the accept cycle issues the palette read at the current
// DAC index; the execute state then applies the update and loads the output
// register. The palette memory read is registered, hence the split.
// Reset is synchronous; the palette valid bits clear at once, no sweep.
// A stalled result holds the update stage, and req_stall stays high until
// the waiting result moves out.
// ----------------------------------------------------------------------------
module vga_dac_palette_port_top #(
   parameter int PALETTE_ENTRIES = vdp_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [15:0] req_port,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_read_data,
   output logic        rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic        cmd_ff;
   logic [15:0] port_ff;
   logic [7:0]  wdata_ff;

   logic [1:0]                    video_mode_ff;
   logic [3:0]                    color_bits_ff;
   logic [vdp_pkg::INDEX_W-1:0]   dac_index_ff, dac_index_in;
   logic [1:0]                    step_ff, step_in;
   logic [vdp_pkg::ENTRY_W-1:0]   acc_ff, acc_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [vdp_pkg::COMP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                          rsp_status_ff, rsp_status_in;

   vdp_pkg::mem_req_type          mem_req;
   logic [vdp_pkg::ENTRY_W-1:0]   mem_rd_data;

   logic                          req_xfer;
   logic                          exec_fire;
   logic                          in_range;
   logic [vdp_pkg::INDEX_W-1:0]   mask;
   logic [4:0]                    shift;
   logic [vdp_pkg::ENTRY_W-1:0]   entry;
   logic [vdp_pkg::ENTRY_W-1:0]   acc_sum;
   logic [vdp_pkg::ENTRY_W-1:0]   entry_shr;
   logic [vdp_pkg::INDEX_W-1:0]   index_inc;
   logic                          last_comp;
   logic                          mode_pal;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   assign in_range  = {1'b0, dac_index_ff} < (vdp_pkg::INDEX_W + 1)'(PALETTE_ENTRIES);
   assign mask      = vdp_pkg::index_mask(color_bits_ff);
   assign shift     = vdp_pkg::comp_shift(step_ff);
   assign entry     = in_range ? mem_rd_data : '0;
   assign entry_shr = entry >> shift;
   assign acc_sum   = acc_ff | (vdp_pkg::ENTRY_W'(wdata_ff[5:0]) << shift);
   assign index_inc = (dac_index_ff + 1'b1) & mask;
   assign last_comp = (step_ff >= vdp_pkg::STEP_BLUE);
   assign mode_pal  = (video_mode_ff == vdp_pkg::MODE_PALETTE);

   vdp_palette_mem #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      dac_index_in  = dac_index_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;

      mem_req.rd_en   = req_xfer;
      mem_req.rd_addr = dac_index_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = dac_index_ff;
      mem_req.wr_data = acc_sum;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = 1'b1;
               if (video_mode_ff != vdp_pkg::MODE_NONE) begin
                  if (cmd_ff == vdp_pkg::CMD_READ) begin
                     if (port_ff == vdp_pkg::PORT_DAC_DATA && mode_pal) begin
                        rsp_data_in   = entry_shr[vdp_pkg::COMP_W-1:0];
                        rsp_status_in = 1'b0;
                        if (last_comp) begin
                           step_in      = vdp_pkg::STEP_RED;
                           dac_index_in = index_inc;
                        end else begin
                           step_in = step_ff + 2'd1;
                        end
                     end else if (port_ff == vdp_pkg::PORT_INPUT_STATUS) begin
                        rsp_data_in   = vdp_pkg::RETRACE_STATUS;
                        rsp_status_in = 1'b0;
                     end
                  end else if (mode_pal) begin
                     if (port_ff == vdp_pkg::PORT_DAC_READ_INDEX ||
                         port_ff == vdp_pkg::PORT_DAC_WRITE_INDEX) begin
                        dac_index_in  = wdata_ff & mask;
                        step_in       = vdp_pkg::STEP_RED;
                        acc_in        = '0;
                        rsp_status_in = 1'b0;
                     end else if (port_ff == vdp_pkg::PORT_DAC_DATA) begin
                        rsp_status_in = 1'b0;
                        if (last_comp) begin
                           // store the finished colour if the index is in range, then move on
                           mem_req.wr_en = in_range;
                           step_in       = vdp_pkg::STEP_RED;
                           acc_in        = '0;
                           dac_index_in  = index_inc;
                        end else begin
                           step_in = step_ff + 2'd1;
                           acc_in  = acc_sum;
                        end
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         video_mode_ff <= vdp_pkg::MODE_NONE;
         color_bits_ff <= 4'd8;
         dac_index_ff  <= '0;
         step_ff       <= vdp_pkg::STEP_RED;
         acc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dac_index_ff <= dac_index_in;
         step_ff      <= step_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               vdp_pkg::CSR_VIDEO_MODE: video_mode_ff <= csr_wdata[1:0];
               vdp_pkg::CSR_COLOR_BITS: color_bits_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff   <= req_cmd;
         port_ff  <= req_port;
         wdata_ff <= req_write_data;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== rtl/vdp_palette_mem.sv =====
// ----------------------------------------------------------------------------
// vdp_palette_mem
// Palette store: one write port, one registered read port. Per-entry valid
// bits make every entry read as zero after reset until it is written.
// ----------------------------------------------------------------------------
module vdp_palette_mem #(
   parameter int ENTRIES = vdp_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vdp_pkg::mem_req_type        mem_req,
   output logic [vdp_pkg::ENTRY_W-1:0] rd_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [vdp_pkg::ENTRY_W-1:0] mem [ENTRIES];
   logic [ENTRIES-1:0]          valid_ff;
   logic [vdp_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                        rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[IDX_W-1:0]] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr[IDX_W-1:0]] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.rd_addr[IDX_W-1:0]];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
